// ----- rtl/core/asrb_pkg.sv -----
`default_nettype none

package asrb_pkg;

   localparam int DEPTH_DEFAULT        = 4096;
   localparam int MAX_CHANNELS_DEFAULT = 8;

   localparam int SAMPLE_W  = 32;
   localparam int LEN_W     = 12;
   localparam int CAP_W     = 13;
   localparam int CHAN_W    = 4;
   localparam int REQ_DATA_W = 48;   // sample_bits + batch_length, padded to bytes
   localparam int REQ_USER_W = 2;
   localparam int RSP_USER_W = 3;

   localparam logic [CAP_W-1:0]  CAPACITY_RESET = 13'd4096;
   localparam logic [CHAN_W-1:0] CHANNELS_RESET = 4'd2;

   // register index, taken from csr_paddr[2]
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_CHANNELS = 1'b1;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef struct packed {
      logic                pull;
      logic [SAMPLE_W-1:0] sample;
      logic [LEN_W-1:0]    len;
      logic                first;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic                kind;
      logic [SAMPLE_W-1:0] sample;
      logic                accepted;
      logic                underrun;
      logic                frame_end;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/asrb_front.sv -----
`default_nettype none

module asrb_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [asrb_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire logic                                  req_tlast,
   input  wire logic [asrb_pkg::REQ_USER_W-1:0]       req_tuser,
   output logic                                       cmd_valid,
   input  wire logic                                  cmd_ready,
   output asrb_pkg::cmd_type                          cmd
);

   asrb_pkg::cmd_type q_ff [2];
   asrb_pkg::cmd_type new_cmd;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   always_comb begin
      new_cmd.pull   = (req_tuser[0] == asrb_pkg::OP_PULL);
      new_cmd.sample = req_tdata[asrb_pkg::SAMPLE_W-1:0];
      new_cmd.len    = req_tdata[asrb_pkg::SAMPLE_W +: asrb_pkg::LEN_W];
      new_cmd.first  = req_tuser[1];
      new_cmd.last   = req_tlast;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[rd_ff];

   assign push = req_tvalid && req_tready;
   assign pop  = cmd_valid && cmd_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/asrb_rsp_q.sv -----
`default_nettype none

module asrb_rsp_q (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              res_valid,
   input  wire asrb_pkg::rsp_type                 res,
   output logic [1:0]                             level,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [asrb_pkg::SAMPLE_W-1:0]          rsp_tdata,
   output logic                                   rsp_tlast,
   output logic [asrb_pkg::RSP_USER_W-1:0]        rsp_tuser
);

   asrb_pkg::rsp_type ent_ff [2];
   asrb_pkg::rsp_type head;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign head       = ent_ff[rd_ff];
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = head.sample;
   assign rsp_tlast  = head.frame_end;
   assign rsp_tuser  = {head.underrun, head.accepted, head.kind};

   assign pop   = rsp_tvalid && rsp_tready;
   // occupancy once this cycle's beat has left; the back end issues against it
   assign level = cnt_ff - {1'b0, pop};

   always_comb begin
      wr_in  = res_valid ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = level + {1'b0, res_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         ent_ff[wr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/asrb_back.sv -----
`default_nettype none

module asrb_back #(
   parameter int DEPTH        = asrb_pkg::DEPTH_DEFAULT,
   parameter int MAX_CHANNELS = asrb_pkg::MAX_CHANNELS_DEFAULT,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CAPW = PW + 1,
   localparam int EW   = $clog2(MAX_CHANNELS + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CAPW-1:0]       eff_cap,
   input  wire logic [EW-1:0]         eff_ch,
   input  wire logic                  flush,
   input  wire logic                  cmd_valid,
   output logic                       cmd_ready,
   input  wire asrb_pkg::cmd_type     cmd,
   input  wire logic [1:0]            level,
   output logic                       res_valid,
   output asrb_pkg::rsp_type          res
);

   localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int LW = (CAPW > asrb_pkg::LEN_W) ? CAPW : asrb_pkg::LEN_W;
   localparam int XW = (IW + 1 > EW) ? IW + 1 : EW;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_PULL = 2'b10
   } back_state_type;

   typedef struct packed {
      logic kind;
      logic use_mem;
      logic accepted;
      logic underrun;
      logic frame_end;
   } stage_type;

   logic [asrb_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [asrb_pkg::SAMPLE_W-1:0] rdata_ff;

   back_state_type state_ff, state_in;
   logic [PW-1:0]  rp_ff, rp_in;
   logic [PW-1:0]  cwp_ff, cwp_in;
   logic [PW-1:0]  swp_ff, swp_in;
   logic           drop_ff, drop_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           s1_valid_ff, s1_valid_in;
   stage_type      s1_ff, s1_in;

   logic           issue_ok, take, push_go;
   logic [PW-1:0]  base, nxt_w, nxt_r;
   logic [CAPW-1:0] room;
   logic           drop_now, do_write, frame_last;
   logic [PW-1:0]  swp_after;
   logic           rd_en;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                             input logic [CAPW-1:0] cap);
      logic [CAPW-1:0] n;
      n = {1'b0, p} + CAPW'(1);
      advance = (n >= cap) ? '0 : n[PW-1:0];
   endfunction

   // a result issued now goes through s1 into the queue; keep a slot free for it
   assign issue_ok  = ({1'b0, level} + {2'b00, s1_valid_ff}) <= 3'd1;
   assign cmd_ready = (state_ff == ST_IDLE) && issue_ok;
   assign take      = cmd_valid && cmd_ready;
   assign push_go   = take && !cmd.pull;

   always_comb begin
      base  = cmd.first ? cwp_ff : swp_ff;
      nxt_w = advance(base, eff_cap);
      nxt_r = advance(rp_ff, eff_cap);
      // free space + 1
      if (rp_ff > cwp_ff) begin
         room = {1'b0, rp_ff} - {1'b0, cwp_ff};
      end else begin
         room = eff_cap + {1'b0, rp_ff} - {1'b0, cwp_ff};
      end
      drop_now   = cmd.first ? (LW'(cmd.len) >= LW'(room)) : drop_ff;
      do_write   = push_go && !drop_now && (nxt_w != rp_ff);
      swp_after  = (!drop_now && (nxt_w != rp_ff)) ? nxt_w : base;
      frame_last = (XW'(idx_ff) + XW'(1)) == XW'(eff_ch);
   end

   always_comb begin
      state_in    = state_ff;
      rp_in       = rp_ff;
      cwp_in      = cwp_ff;
      swp_in      = swp_ff;
      drop_in     = drop_ff;
      idx_in      = idx_ff;
      s1_valid_in = 1'b0;
      s1_in       = s1_ff;
      rd_en       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && cmd.pull) begin
               state_in = ST_PULL;
               idx_in   = '0;
            end else if (push_go) begin
               drop_in = drop_now;
               if (cmd.last) begin
                  if (!drop_now) begin
                     cwp_in = swp_after;
                     swp_in = swp_after;
                  end else begin
                     swp_in = cwp_ff;
                  end
                  s1_valid_in     = 1'b1;
                  s1_in.kind      = asrb_pkg::KIND_STATUS;
                  s1_in.use_mem   = 1'b0;
                  s1_in.accepted  = !drop_now;
                  s1_in.underrun  = 1'b0;
                  s1_in.frame_end = 1'b1;
               end else begin
                  swp_in = swp_after;
               end
            end
         end
         ST_PULL: begin
            if (issue_ok) begin
               s1_valid_in     = 1'b1;
               s1_in.kind      = asrb_pkg::KIND_SAMPLE;
               s1_in.accepted  = 1'b0;
               s1_in.frame_end = frame_last;
               if (rp_ff != cwp_ff) begin
                  rd_en          = 1'b1;
                  rp_in          = nxt_r;
                  s1_in.use_mem  = 1'b1;
                  s1_in.underrun = 1'b0;
               end else begin
                  s1_in.use_mem  = 1'b0;
                  s1_in.underrun = 1'b1;
               end
               if (frame_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (flush) begin
         rp_in   = '0;
         cwp_in  = '0;
         swp_in  = '0;
         drop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rp_ff       <= '0;
         cwp_ff      <= '0;
         swp_ff      <= '0;
         drop_ff     <= 1'b0;
         idx_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rp_ff       <= rp_in;
         cwp_ff      <= cwp_in;
         swp_ff      <= swp_in;
         drop_ff     <= drop_in;
         idx_ff      <= idx_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[base] <= cmd.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rp_ff];
      end
   end

   always_comb begin
      res_valid     = s1_valid_ff;
      res.kind      = s1_ff.kind;
      res.sample    = s1_ff.use_mem ? rdata_ff : '0;
      res.accepted  = s1_ff.accepted;
      res.underrun  = s1_ff.underrun;
      res.frame_end = s1_ff.frame_end;
   end

endmodule

`default_nettype wire

// ----- rtl/core/audio_sample_ring_buffer_unit.sv -----
`default_nettype none

// Sample ring buffer for 32-bit audio words with one slot always kept empty.
// Push beats (tuser[0]=0) carry one sample each; the first beat of a batch
// (tuser[1]=1) carries the batch length, and a batch that does not fit the free
// space is dropped as a whole. The last beat of a batch (tlast) commits it and
// returns one status beat. A pull beat returns channel_count sample beats,
// zero-filled with the underrun flag once committed data runs out. A push beat
// is handled in the back end's idle state; a pull of N channels keeps it in
// its pull state until all N beats are issued, paced by the single read port
// of the sample memory (one read per cycle) and by the two-entry result queue
// when the consumer stalls. Writing capacity flushes all pointers; the sample
// memory itself is never cleared, so there is no clearing pass after reset.
module audio_sample_ring_buffer_unit #(
   parameter int DEPTH        = asrb_pkg::DEPTH_DEFAULT,
   parameter int MAX_CHANNELS = asrb_pkg::MAX_CHANNELS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: sample_bits[31:0], batch_length[43:32], zero pad[47:44]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [asrb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              req_tlast,
   // tuser: op[0], batch_first[1]
   input  wire logic [asrb_pkg::REQ_USER_W-1:0]   req_tuser,
   // tdata: out_sample[31:0]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [asrb_pkg::SAMPLE_W-1:0]          rsp_tdata,
   output logic                                   rsp_tlast,
   // tuser: kind[0], accepted[1], underrun[2]
   output logic [asrb_pkg::RSP_USER_W-1:0]        rsp_tuser,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [2:0]                        csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAPW = PW + 1;
   localparam int EW   = $clog2(MAX_CHANNELS + 1);
   localparam int XW   = (CAPW > asrb_pkg::CAP_W) ? CAPW : asrb_pkg::CAP_W;

   logic [asrb_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [asrb_pkg::CHAN_W-1:0] chan_ff, chan_in;
   logic                        csr_wr, flush;
   logic [XW-1:0]               cap_x, cap_clamp;
   logic [6:0]                  ch_x, ch_clamp;
   logic [CAPW-1:0]             eff_cap;
   logic [EW-1:0]               eff_ch;

   logic                        cmd_valid, cmd_ready;
   asrb_pkg::cmd_type           cmd;
   logic                        res_valid;
   asrb_pkg::rsp_type           res;
   logic [1:0]                  level;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign flush      = csr_wr && (csr_paddr[2] == asrb_pkg::REG_CAPACITY);

   always_comb begin
      cap_in  = cap_ff;
      chan_in = chan_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            asrb_pkg::REG_CAPACITY: cap_in  = csr_pwdata[asrb_pkg::CAP_W-1:0];
            asrb_pkg::REG_CHANNELS: chan_in = csr_pwdata[asrb_pkg::CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         asrb_pkg::REG_CAPACITY: csr_prdata = 32'(cap_ff);
         asrb_pkg::REG_CHANNELS: csr_prdata = 32'(chan_ff);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= asrb_pkg::CAPACITY_RESET;
         chan_ff <= asrb_pkg::CHANNELS_RESET;
      end else begin
         cap_ff  <= cap_in;
         chan_ff <= chan_in;
      end
   end

   // clamp capacity to 2..DEPTH and channel count to 1..MAX_CHANNELS
   always_comb begin
      cap_x = XW'(cap_ff);
      priority if (cap_x < XW'(2)) begin
         cap_clamp = XW'(2);
      end else if (cap_x > XW'(DEPTH)) begin
         cap_clamp = XW'(DEPTH);
      end else begin
         cap_clamp = cap_x;
      end
      ch_x = 7'(chan_ff);
      priority if (ch_x == 7'd0) begin
         ch_clamp = 7'd1;
      end else if (ch_x > 7'(MAX_CHANNELS)) begin
         ch_clamp = 7'(MAX_CHANNELS);
      end else begin
         ch_clamp = ch_x;
      end
      eff_cap = cap_clamp[CAPW-1:0];
      eff_ch  = ch_clamp[EW-1:0];
   end

   asrb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   asrb_back #(
      .DEPTH        (DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .eff_cap   (eff_cap),
      .eff_ch    (eff_ch),
      .flush     (flush),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .level     (level),
      .res_valid (res_valid),
      .res       (res)
   );

   asrb_rsp_q u_rsp_q (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .level      (level),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // a result from the back end always finds a free queue slot
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (level <= 2'd1))
      else $error("result queue overflow");

   // status beats always close their item
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[0] == asrb_pkg::KIND_STATUS)) |-> rsp_tlast)
      else $error("status beat without tlast");

   // underrun beats are zero samples
   a_underrun_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |->
         ((rsp_tdata == '0) && (rsp_tuser[0] == asrb_pkg::KIND_SAMPLE)))
      else $error("underrun beat carries data");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;

   localparam int RING_DEPTH     = asrb_pkg::DEPTH_DEFAULT;
   localparam int RING_CHANNELS  = asrb_pkg::MAX_CHANNELS_DEFAULT;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_BEATS    = 44;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // tdata: sample_bits[31:0], batch_length[43:32], zero pad[47:44]
   logic [asrb_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tlast = 1'b0;
   // tuser: op[0], batch_first[1]
   logic [asrb_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // tdata: out_sample[31:0]
   logic [asrb_pkg::SAMPLE_W-1:0]   rsp_tdata;
   logic                            rsp_tlast;
   // tuser: kind[0], accepted[1], underrun[2]
   logic [asrb_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [2:0]                      csr_paddr = '0;
   logic [31:0]                     csr_pwdata = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   audio_sample_ring_buffer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ring predictor state
   logic [asrb_pkg::SAMPLE_W-1:0] ring_mem [0:RING_DEPTH-1];
   int unsigned                   rd_ptr;
   int unsigned                   commit_ptr;
   int unsigned                   stage_ptr;
   bit                            dropping;
   logic [asrb_pkg::CAP_W-1:0]    cap_reg;
   logic [asrb_pkg::CHAN_W-1:0]   chan_reg;

   asrb_pkg::rsp_type outbound[$];
   int      fault_count;
   int      send_gap_pct;
   int      rsp_stall_pct;
   int      quiet_cycles;

   function automatic int unsigned ring_capacity();
      if (cap_reg < 2) return 2;
      if (cap_reg > RING_DEPTH) return RING_DEPTH;
      return 32'(cap_reg);
   endfunction

   function automatic int unsigned frame_channels();
      if (chan_reg == 0) return 1;
      if (chan_reg > RING_CHANNELS) return RING_CHANNELS;
      return 32'(chan_reg);
   endfunction

   function automatic int unsigned ring_next(input int unsigned p,
                                             input int unsigned cap);
      return (p + 1 >= cap) ? 0 : p + 1;
   endfunction

   task automatic ring_step(input asrb_pkg::cmd_type c);
      int unsigned       cap;
      int unsigned       ch;
      int unsigned       room;
      int unsigned       nxt;
      asrb_pkg::rsp_type r;
      cap = ring_capacity();
      if (rd_ptr >= cap) rd_ptr = 0;
      if (commit_ptr >= cap) commit_ptr = 0;
      if (stage_ptr >= cap) stage_ptr = 0;
      if (c.pull == asrb_pkg::OP_PUSH) begin
         if (c.first) begin
            if (rd_ptr > commit_ptr) room = rd_ptr - commit_ptr - 1;
            else room = cap - commit_ptr + rd_ptr - 1;
            dropping = c.len > room;
            stage_ptr = commit_ptr;
         end
         if (!dropping) begin
            nxt = ring_next(stage_ptr, cap);
            // a sample that would fill the ring is lost
            if (nxt != rd_ptr) begin
               ring_mem[stage_ptr] = c.sample;
               stage_ptr = nxt;
            end
         end
         if (c.last) begin
            if (!dropping) commit_ptr = stage_ptr;
            else stage_ptr = commit_ptr;
            r = '0;
            r.kind = asrb_pkg::KIND_STATUS;
            r.accepted = !dropping;
            r.frame_end = 1'b1;
            outbound.push_back(r);
         end
      end else begin
         ch = frame_channels();
         for (int unsigned i = 0; i < ch; i++) begin
            r = '0;
            r.kind = asrb_pkg::KIND_SAMPLE;
            r.underrun = 1'b1;
            if (rd_ptr != commit_ptr) begin
               r.sample = ring_mem[rd_ptr];
               r.underrun = 1'b0;
               rd_ptr = ring_next(rd_ptr, cap);
            end
            r.frame_end = (i + 1 == ch);
            outbound.push_back(r);
         end
      end
   endtask

   task automatic log_fault(input string what, input asrb_pkg::rsp_type want,
                            input asrb_pkg::rsp_type got);
      fault_count++;
      if (fault_count <= 10)
         $display({"%s: expected kind=%0d sample=%h acc=%0d und=%0d end=%0d,",
                   " got kind=%0d sample=%h acc=%0d und=%0d end=%0d"},
                  what, want.kind, want.sample, want.accepted, want.underrun,
                  want.frame_end, got.kind, got.sample, got.accepted, got.underrun,
                  got.frame_end);
   endtask

   // result checker
   always @(posedge clock) begin
      asrb_pkg::rsp_type got;
      asrb_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind      = rsp_tuser[0];
         got.sample    = rsp_tdata;
         got.accepted  = rsp_tuser[1];
         got.underrun  = rsp_tuser[2];
         got.frame_end = rsp_tlast;
         if (outbound.size() == 0) begin
            log_fault("unexpected beat", '0, got);
         end else begin
            want = outbound.pop_front();
            if (got !== want) log_fault("beat mismatch", want, got);
         end
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL audio_sample_ring_buffer_unit");
            $finish;
         end
      end
   end

   // entered and left at a rising edge
   task automatic send_beat(input asrb_pkg::cmd_type c);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, c.len, c.sample};
      req_tuser  <= {c.first, c.pull};
      req_tlast  <= c.last;
      do @(posedge clock); while (!req_tready);
      ring_step(c);
   endtask

   task automatic push_beat(input logic [31:0] smp, input logic [11:0] len,
                            input logic first, input logic last);
      asrb_pkg::cmd_type c;
      c.pull = asrb_pkg::OP_PUSH;
      c.sample = smp;
      c.len = len;
      c.first = first;
      c.last = last;
      send_beat(c);
   endtask

   task automatic pull_frame();
      asrb_pkg::cmd_type c;
      c.pull = asrb_pkg::OP_PULL;
      c.sample = $urandom;
      c.len = 12'($urandom);
      c.first = 1'($urandom_range(1));
      c.last = 1'($urandom_range(1));
      send_beat(c);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (outbound.size() != 0) @(posedge clock);
      // trailing push beats yield nothing, give them time to land
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == asrb_pkg::REG_CAPACITY) begin
         cap_reg = value[asrb_pkg::CAP_W-1:0];
         rd_ptr = 0;
         commit_ptr = 0;
         stage_ptr = 0;
         dropping = 1'b0;
      end else begin
         chan_reg = value[asrb_pkg::CHAN_W-1:0];
      end
   endtask

   task automatic configure(input logic [31:0] cap, input logic [31:0] ch);
      write_reg(asrb_pkg::REG_CAPACITY, cap);
      write_reg(asrb_pkg::REG_CHANNELS, ch);
   endtask

   task automatic test_reset_setting();
      push_beat(32'hFFFF_FFFF, 12'd1, 1'b1, 1'b1);
      pull_frame();
      push_beat(32'h0, 12'd0, 1'b1, 1'b1);   // zero length still fits
      pull_frame();
   endtask

   task automatic test_dropped_batch();
      push_beat(32'hA5A5_0001, 12'd2, 1'b1, 1'b0);
      push_beat(32'h5A5A_0002, 12'd0, 1'b0, 1'b1);
      push_beat(32'h1234_5678, 12'hFFF, 1'b1, 1'b0);
      push_beat(32'h8765_4321, 12'd0, 1'b0, 1'b1);
      // drop decision sticks until the next first beat
      push_beat(32'hDEAD_BEEF, 12'd0, 1'b0, 1'b0);
      push_beat(32'hCAFE_F00D, 12'd0, 1'b0, 1'b1);
      pull_frame();
   endtask

   task automatic test_overlong_batch();
      configure(4, 8);
      push_beat($urandom, 12'd1, 1'b1, 1'b0);
      repeat (3) push_beat($urandom, 12'd0, 1'b0, 1'b0);
      push_beat($urandom, 12'd0, 1'b0, 1'b1);
      pull_frame();
      push_beat($urandom, 12'd2, 1'b1, 1'b0);
      pull_frame();                             // open batch is not visible yet
      push_beat($urandom, 12'd0, 1'b0, 1'b1);
      push_beat($urandom, 12'd0, 1'b0, 1'b1);   // continues without a first mark
      pull_frame();
   endtask

   task automatic test_register_limits();
      configure(8191, 15);
      push_beat($urandom, 12'd1, 1'b1, 1'b1);
      pull_frame();
      configure(1, 0);
      push_beat($urandom, 12'd1, 1'b1, 1'b1);
      push_beat($urandom, 12'd1, 1'b1, 1'b1);
      pull_frame();
      configure(0, 9);
      configure(5000, 1);
   endtask

   task automatic random_traffic(input int beats);
      int          sent;
      int          pick;
      int unsigned span;
      int unsigned n;
      logic [11:0] len;
      sent = 0;
      while (sent < beats) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            pull_frame();
            sent++;
         end else if (pick < 85) begin
            span = ring_capacity();
            if (span > 10) span = 10;
            n = $urandom_range(span, 1);
            len = ($urandom_range(9) == 0) ? 12'($urandom_range(ring_capacity(), 0))
                                           : 12'(n);
            for (int unsigned i = 0; i < n; i++)
               push_beat($urandom, (i == 0) ? len : 12'($urandom), i == 0, i + 1 == n);
            sent += n;
         end else begin
            n = $urandom_range(6, 1);
            for (int unsigned i = 0; i < n; i++)
               push_beat($urandom, 12'($urandom), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            sent += n;
         end
      end
   endtask

   task automatic test_random_no_idle();
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      configure(16, 3);
      random_traffic(PHASE_BEATS);
   endtask

   task automatic test_random_sender_gaps();
      send_gap_pct = 55;
      rsp_stall_pct = 0;
      configure(4096, 8);
      random_traffic(PHASE_BEATS);
   endtask

   task automatic test_random_receiver_stall();
      send_gap_pct = 0;
      rsp_stall_pct = 55;
      configure(2, 1);
      random_traffic(PHASE_BEATS);
   endtask

   task automatic test_random_both_idle();
      send_gap_pct = 16;
      rsp_stall_pct = 16;
      configure($urandom_range(40, 3), $urandom_range(8, 1));
      random_traffic(PHASE_BEATS);
   endtask

   initial begin
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      cap_reg = asrb_pkg::CAPACITY_RESET;
      chan_reg = asrb_pkg::CHANNELS_RESET;
      rd_ptr = 0;
      commit_ptr = 0;
      stage_ptr = 0;
      dropping = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_setting();
      test_dropped_batch();
      test_overlong_batch();
      test_register_limits();
      test_random_no_idle();
      test_random_sender_gaps();
      test_random_receiver_stall();
      test_random_both_idle();

      req_tvalid <= 1'b0;
      while (outbound.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && outbound.size() == 0) begin
         $display("PASS audio_sample_ring_buffer_unit");
      end else begin
         $display("FAIL audio_sample_ring_buffer_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/asrb_pkg.sv
rtl/core/asrb_front.sv
rtl/core/asrb_rsp_q.sv
rtl/core/asrb_back.sv
rtl/core/audio_sample_ring_buffer_unit.sv
tb/tb_top.sv
